>>> sv/c2s_pkg.sv
// Package with the widths, constants, types and gain tables of the Cartesian to spherical converter.
package c2s_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD         = 40 - COORD_WIDTH;

  localparam int DATA_W    = COORD_WIDTH + GUARD + 4;
  localparam int ANG_W     = 32;
  localparam int ANG_OUT_W = 16;
  localparam int IDX_W     = 5;

  localparam int INV_W    = 22;
  localparam int INV_FRAC = 22;
  localparam int VAL_W    = DATA_W - 1;
  localparam int LO_W     = 22;
  localparam int HI_W     = VAL_W - LO_W;
  localparam int PROD_W   = VAL_W + INV_W;

  localparam int RAD_SHIFT = INV_FRAC + GUARD;
  localparam int EL_MAX    = 1 << (ANG_OUT_W - 2);

  localparam logic [ANG_W-1:0]  ANG_PI     = ANG_W'(64'd1 << (ANG_W - 1));
  localparam logic [ANG_W-1:0]  ROUND_HALF = ANG_W'(64'd1 << (ANG_W - ANG_OUT_W - 1));
  localparam logic [PROD_W-1:0] RND_RHO    = PROD_W'(1) << (INV_FRAC - 1);
  localparam logic [PROD_W-1:0] RND_RAD    = PROD_W'(1) << (RAD_SHIFT - 1);

  localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Square of the CORDIC gain in Q30, built as the truncated product of (1 + 2^-2i).
  function automatic logic [63:0] gain_sq();
    logic [63:0] g;
    g = 64'd1 << 30;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      g = g + (g >> (2 * i));
    end
    return g;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = v;
    res = '0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  localparam logic [63:0] GAIN_SQ = gain_sq();
  localparam logic [63:0] GAIN    = isqrt64(GAIN_SQ << 30);
  localparam logic [63:0] INV1_FULL = ((64'd1 << 52) + (GAIN >> 1)) / GAIN;
  localparam logic [63:0] INV2_FULL = ((64'd1 << 52) + (GAIN_SQ >> 1)) / GAIN_SQ;
  localparam logic [INV_W-1:0] INV1 = INV1_FULL[INV_W-1:0];
  localparam logic [INV_W-1:0] INV2 = INV2_FULL[INV_W-1:0];

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [ANG_W-1:0]  ang;
  } cordic_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] z;
    logic [ANG_W-1:0]       az;
    logic                   pz;
    logic                   org;
  } side_t;

endpackage

>>> sv/c2s_cell.sv
// One vectoring CORDIC micro-rotation cell with its own pipeline register.
module c2s_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [c2s_pkg::IDX_W-1:0] shift_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  c2s_pkg::cordic_t         data_i,
  input  c2s_pkg::side_t           side_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output c2s_pkg::cordic_t         data_o,
  output c2s_pkg::side_t           side_o
);

  logic                             valid_q;
  c2s_pkg::cordic_t                 data_d;
  c2s_pkg::cordic_t                 data_q;
  c2s_pkg::side_t                   side_q;
  logic signed [c2s_pkg::DATA_W-1:0] xs;
  logic signed [c2s_pkg::DATA_W-1:0] ys;

  assign xs = $signed(data_i.x) >>> shift_i;
  assign ys = $signed(data_i.y) >>> shift_i;

  always_comb begin
    data_d = data_i;
    if (!data_i.y[c2s_pkg::DATA_W-1]) begin
      data_d.x   = data_i.x + ys;
      data_d.y   = data_i.y - xs;
      data_d.ang = data_i.ang + c2s_pkg::ATAN_TAB[shift_i];
    end else begin
      data_d.x   = data_i.x - ys;
      data_d.y   = data_i.y + xs;
      data_d.ang = data_i.ang - c2s_pkg::ATAN_TAB[shift_i];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign side_o  = side_q;

endmodule

>>> sv/c2s_scale.sv
// Two-stage gain correction: split multiply by an inverse gain, then sum with rounding.
module c2s_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [c2s_pkg::INV_W-1:0]  inv_i,
  input  logic [c2s_pkg::PROD_W-1:0] rnd_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [c2s_pkg::VAL_W-1:0]  val_i,
  input  logic [c2s_pkg::ANG_W-1:0]  ang_i,
  input  c2s_pkg::side_t            side_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [c2s_pkg::PROD_W-1:0] prod_o,
  output logic [c2s_pkg::ANG_W-1:0]  ang_o,
  output c2s_pkg::side_t            side_o
);

  logic                                        a_valid_q;
  logic                                        a_ready;
  logic [c2s_pkg::LO_W+c2s_pkg::INV_W-1:0]     lo_d;
  logic [c2s_pkg::LO_W+c2s_pkg::INV_W-1:0]     lo_q;
  logic [c2s_pkg::HI_W+c2s_pkg::INV_W-1:0]     hi_d;
  logic [c2s_pkg::HI_W+c2s_pkg::INV_W-1:0]     hi_q;
  logic [c2s_pkg::ANG_W-1:0]                   a_ang_q;
  c2s_pkg::side_t                              a_side_q;
  logic                                        b_valid_q;
  logic [c2s_pkg::PROD_W-1:0]                  sum_d;
  logic [c2s_pkg::PROD_W-1:0]                  sum_q;
  logic [c2s_pkg::ANG_W-1:0]                   b_ang_q;
  c2s_pkg::side_t                              b_side_q;

  assign lo_d = val_i[c2s_pkg::LO_W-1:0] * inv_i;
  assign hi_d = val_i[c2s_pkg::VAL_W-1:c2s_pkg::LO_W] * inv_i;
  assign sum_d = {hi_q, {c2s_pkg::LO_W{1'b0}}} + c2s_pkg::PROD_W'(lo_q) + rnd_i;

  assign ready_o = !a_valid_q || a_ready;
  assign a_ready = !b_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        a_valid_q <= valid_i;
      end
      if (a_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      a_ang_q  <= ang_i;
      a_side_q <= side_i;
    end
    if (a_valid_q && a_ready) begin
      sum_q    <= sum_d;
      b_ang_q  <= a_ang_q;
      b_side_q <= a_side_q;
    end
  end

  assign valid_o = b_valid_q;
  assign prod_o  = sum_q;
  assign ang_o   = b_ang_q;
  assign side_o  = b_side_q;

endmodule

>>> sv/c2s_fmt.sv
// Output stage: radius shift and saturation, angle rounding and elevation clamp.
module c2s_fmt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [c2s_pkg::PROD_W-1:0]           prod_i,
  input  logic [c2s_pkg::ANG_W-1:0]            ang_i,
  input  c2s_pkg::side_t                      side_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [c2s_pkg::COORD_WIDTH-1:0]      radius_o,
  output logic signed [c2s_pkg::ANG_OUT_W-1:0] azimuth_o,
  output logic signed [c2s_pkg::ANG_OUT_W-1:0] elevation_o
);

  logic                                         valid_q;
  logic [c2s_pkg::PROD_W-c2s_pkg::RAD_SHIFT-1:0] rad_full;
  logic [c2s_pkg::COORD_WIDTH-1:0]              rad_d;
  logic [c2s_pkg::COORD_WIDTH-1:0]              rad_q;
  logic [c2s_pkg::ANG_W-1:0]                    az_sum;
  logic [c2s_pkg::ANG_OUT_W-1:0]                az_d;
  logic [c2s_pkg::ANG_OUT_W-1:0]                az_q;
  logic [c2s_pkg::ANG_W:0]                      el_sum;
  logic signed [c2s_pkg::ANG_OUT_W:0]           el_r;
  logic signed [c2s_pkg::ANG_OUT_W:0]           el_hi;
  logic signed [c2s_pkg::ANG_OUT_W:0]           el_c;
  logic [c2s_pkg::ANG_OUT_W-1:0]                el_d;
  logic [c2s_pkg::ANG_OUT_W-1:0]                el_q;

  assign rad_full = prod_i[c2s_pkg::PROD_W-1:c2s_pkg::RAD_SHIFT];
  assign rad_d    = (|rad_full[c2s_pkg::PROD_W-c2s_pkg::RAD_SHIFT-1:c2s_pkg::COORD_WIDTH]) ?
                    '1 : rad_full[c2s_pkg::COORD_WIDTH-1:0];

  assign az_sum = side_i.az + c2s_pkg::ROUND_HALF;
  assign az_d   = az_sum[c2s_pkg::ANG_W-1 -: c2s_pkg::ANG_OUT_W];

  assign el_sum = {ang_i[c2s_pkg::ANG_W-1], ang_i} + {1'b0, c2s_pkg::ROUND_HALF};
  assign el_r   = $signed(el_sum[c2s_pkg::ANG_W -: (c2s_pkg::ANG_OUT_W + 1)]);
  assign el_hi  = (c2s_pkg::ANG_OUT_W + 1)'(c2s_pkg::EL_MAX);

  always_comb begin
    el_c = el_r;
    if (el_r > el_hi) begin
      el_c = el_hi;
    end else if (el_r < -el_hi) begin
      el_c = -el_hi;
    end
    el_d = side_i.org ? '0 : el_c[c2s_pkg::ANG_OUT_W-1:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rad_q <= rad_d;
      az_q  <= az_d;
      el_q  <= el_d;
    end
  end

  assign valid_o     = valid_q;
  assign radius_o    = rad_q;
  assign azimuth_o   = $signed(az_q);
  assign elevation_o = $signed(el_q);

endmodule

>>> sv/cartesian_to_spherical.sv
// Top level: pipelined Cartesian to spherical converter built from two chains of CORDIC cells.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   coord_x_i, coord_y_i, coord_z_i
//   out      output     out_valid_o / out_ready_i radius_o, azimuth_o, elevation_o
//
// The pipeline has one input stage, two chains of CORDIC_STAGES cells, two
// multiplier stages after each chain and one output register.
// Every stage takes a new request in every cycle while the output is not stalled, so one point per cycle is sustained.
// Each stage has its own valid bit, so bubbles close up while the output is stalled.
// Reset clears only the valid bits; payload registers are not reset.
module cartesian_to_spherical (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] coord_y_i,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] coord_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [c2s_pkg::COORD_WIDTH-1:0]      radius_o,
  output logic signed [c2s_pkg::ANG_OUT_W-1:0] azimuth_o,
  output logic signed [c2s_pkg::ANG_OUT_W-1:0] elevation_o
);

  localparam int N = c2s_pkg::CORDIC_STAGES;
  localparam int EXT_W = c2s_pkg::DATA_W - c2s_pkg::COORD_WIDTH - c2s_pkg::GUARD;

  logic                      in_valid_q;
  c2s_pkg::cordic_t          in_data_d;
  c2s_pkg::cordic_t          in_data_q;
  c2s_pkg::side_t            in_side_d;
  c2s_pkg::side_t            in_side_q;
  logic [c2s_pkg::DATA_W-1:0] xg;
  logic [c2s_pkg::DATA_W-1:0] yg;

  logic                      c1_valid [N+1];
  logic                      c1_ready [N+1];
  c2s_pkg::cordic_t          c1_data  [N+1];
  c2s_pkg::side_t            c1_side  [N+1];
  logic                      c2_valid [N+1];
  logic                      c2_ready [N+1];
  c2s_pkg::cordic_t          c2_data  [N+1];
  c2s_pkg::side_t            c2_side  [N+1];
  c2s_pkg::cordic_t          c2_head_data;
  c2s_pkg::side_t            c2_head_side;

  logic                      s1_valid;
  logic [c2s_pkg::PROD_W-1:0] s1_prod;
  logic [c2s_pkg::ANG_W-1:0]  s1_ang;
  c2s_pkg::side_t            s1_side;
  logic                      s2_valid;
  logic                      s2_ready;
  logic [c2s_pkg::PROD_W-1:0] s2_prod;
  logic [c2s_pkg::ANG_W-1:0]  s2_ang;
  c2s_pkg::side_t            s2_side;

  assign xg = {{EXT_W{coord_x_i[c2s_pkg::COORD_WIDTH-1]}}, coord_x_i, {c2s_pkg::GUARD{1'b0}}};
  assign yg = {{EXT_W{coord_y_i[c2s_pkg::COORD_WIDTH-1]}}, coord_y_i, {c2s_pkg::GUARD{1'b0}}};

  always_comb begin
    if (coord_x_i[c2s_pkg::COORD_WIDTH-1]) begin
      in_data_d.x   = -xg;
      in_data_d.y   = -yg;
      in_data_d.ang = c2s_pkg::ANG_PI;
    end else begin
      in_data_d.x   = xg;
      in_data_d.y   = yg;
      in_data_d.ang = '0;
    end
    in_side_d.z   = coord_z_i;
    in_side_d.az  = '0;
    in_side_d.pz  = (coord_x_i == '0) && (coord_y_i == '0);
    in_side_d.org = in_side_d.pz && (coord_z_i == '0);
  end

  assign in_ready_o = !in_valid_q || c1_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_d;
      in_side_q <= in_side_d;
    end
  end

  assign c1_valid[0] = in_valid_q;
  assign c1_data[0]  = in_data_q;
  assign c1_side[0]  = in_side_q;

  for (genvar i = 0; i < N; i++) begin : g_c1
    c2s_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (c2s_pkg::IDX_W'(i)),
      .valid_i (c1_valid[i]),
      .ready_o (c1_ready[i]),
      .data_i  (c1_data[i]),
      .side_i  (c1_side[i]),
      .valid_o (c1_valid[i+1]),
      .ready_i (c1_ready[i+1]),
      .data_o  (c1_data[i+1]),
      .side_o  (c1_side[i+1])
    );
  end

  c2s_scale u_scale_rho (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inv_i   (c2s_pkg::INV1),
    .rnd_i   (c2s_pkg::RND_RHO),
    .valid_i (c1_valid[N]),
    .ready_o (c1_ready[N]),
    .val_i   (c1_data[N].x[c2s_pkg::VAL_W-1:0]),
    .ang_i   (c1_data[N].ang),
    .side_i  (c1_side[N]),
    .valid_o (s1_valid),
    .ready_i (c2_ready[0]),
    .prod_o  (s1_prod),
    .ang_o   (s1_ang),
    .side_o  (s1_side)
  );

  always_comb begin
    c2_head_data.x   = {1'b0, s1_prod[c2s_pkg::INV_FRAC +: c2s_pkg::VAL_W]};
    c2_head_data.y   = {{EXT_W{s1_side.z[c2s_pkg::COORD_WIDTH-1]}}, s1_side.z,
                        {c2s_pkg::GUARD{1'b0}}};
    c2_head_data.ang = '0;
    c2_head_side     = s1_side;
    c2_head_side.az  = s1_side.pz ? '0 : s1_ang;
  end

  assign c2_data[0]  = c2_head_data;
  assign c2_side[0]  = c2_head_side;
  assign c2_valid[0] = s1_valid;

  for (genvar i = 0; i < N; i++) begin : g_c2
    c2s_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (c2s_pkg::IDX_W'(i)),
      .valid_i (c2_valid[i]),
      .ready_o (c2_ready[i]),
      .data_i  (c2_data[i]),
      .side_i  (c2_side[i]),
      .valid_o (c2_valid[i+1]),
      .ready_i (c2_ready[i+1]),
      .data_o  (c2_data[i+1]),
      .side_o  (c2_side[i+1])
    );
  end

  c2s_scale u_scale_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inv_i   (c2s_pkg::INV2),
    .rnd_i   (c2s_pkg::RND_RAD),
    .valid_i (c2_valid[N]),
    .ready_o (c2_ready[N]),
    .val_i   (c2_data[N].x[c2s_pkg::VAL_W-1:0]),
    .ang_i   (c2_data[N].ang),
    .side_i  (c2_side[N]),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .prod_o  (s2_prod),
    .ang_o   (s2_ang),
    .side_o  (s2_side)
  );

  c2s_fmt u_fmt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid),
    .ready_o     (s2_ready),
    .prod_i      (s2_prod),
    .ang_i       (s2_ang),
    .side_i      (s2_side),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .radius_o    (radius_o),
    .azimuth_o   (azimuth_o),
    .elevation_o (elevation_o)
  );

  // The x accumulator never goes negative at the end of either rotation chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c1_valid[N] |-> !c1_data[N].x[c2s_pkg::DATA_W-1])
    else $error("planar length out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c2_valid[N] |-> !c2_data[N].x[c2s_pkg::DATA_W-1])
    else $error("radius accumulator out of range");

  // A point on the z axis leaves the first chain with zero planar length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c1_valid[N] && c1_side[N].pz) |-> (c1_data[N].x == '0))
    else $error("nonzero planar length for a point on the z axis");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(elevation_o) <= 16'sd16384 &&
                     $signed(elevation_o) >= -16'sd16384))
    else $error("elevation outside the clamp range");

endmodule

>>> sim/cartesian_to_spherical_test.sv
// Self-checking testbench for the pipelined Cartesian to spherical converter.
`timescale 1ns / 100ps

module cartesian_to_spherical_test;
  import c2s_pkg::*;

  localparam int CW            = COORD_WIDTH;
  localparam int RANDOM_POINTS = 1250;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int MAX_REPORTS   = 10;

  typedef logic signed [CW-1:0] coord_t;
  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [CW-1:0]               radius;
    logic signed [ANG_OUT_W-1:0] azimuth;
    logic signed [ANG_OUT_W-1:0] elevation;
  } sphere_t;

  localparam coord_t COORD_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam u64_t   RADIUS_MAX = (64'd1 << CW) - 1;

  localparam bit [31:0] ARCTAN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  class sphere_scoreboard;
    sphere_t expected_q[$];
    int      mismatches;
    u64_t    inv_gain;
    u64_t    inv_gain_sq;

    function new();
      u64_t gain_sq, rem, root, bt;
      gain_sq = 64'd1 << 30;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        gain_sq += gain_sq >> (2 * i);
      end
      rem  = gain_sq << 30;
      root = 0;
      bt   = 64'd1 << 62;
      while (bt > rem) bt >>= 2;
      while (bt != 0) begin
        if (rem >= root + bt) begin
          rem  -= root + bt;
          root  = (root >> 1) + bt;
        end else begin
          root >>= 1;
        end
        bt >>= 2;
      end
      inv_gain    = ((64'd1 << 52) + (root >> 1)) / root;
      inv_gain_sq = ((64'd1 << 52) + (gain_sq >> 1)) / gain_sq;
      mismatches  = 0;
    endfunction

    function longint vectoring(longint xv, longint yv, inout logic [31:0] angle);
      longint xs, ys;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        xs = xv >>> i;
        ys = yv >>> i;
        if (yv >= 0) begin
          xv    += ys;
          yv    -= xs;
          angle += ARCTAN[i];
        end else begin
          xv    -= ys;
          yv    += xs;
          angle -= ARCTAN[i];
        end
      end
      return xv;
    endfunction

    function void note_request(coord_t cx, coord_t cy, coord_t cz);
      longint      xv, yv, zv, ev;
      u64_t        rho, rad;
      logic [31:0] az, el;
      sphere_t     s;
      s = '0;
      if (cx != 0 || cy != 0 || cz != 0) begin
        xv  = longint'(cx) <<< GUARD;
        yv  = longint'(cy) <<< GUARD;
        zv  = longint'(cz) <<< GUARD;
        az  = '0;
        el  = '0;
        rho = 0;
        if (xv != 0 || yv != 0) begin
          // The left half plane is first turned by pi.
          if (xv < 0) begin
            xv = -xv;
            yv = -yv;
            az = 32'h8000_0000;
          end
          rho = vectoring(xv, yv, az);
          rho = (rho * inv_gain + (64'd1 << 21)) >> 22;
        end
        rho = vectoring(rho, zv, el);
        rad = (rho * inv_gain_sq + (64'd1 << (21 + GUARD))) >> (22 + GUARD);
        if (rad > RADIUS_MAX) rad = RADIUS_MAX;
        az = az + 32'h0000_8000;
        ev = (longint'(signed'(el)) + 32768) >>> 16;
        if (ev > EL_MAX) ev = EL_MAX;
        if (ev < -EL_MAX) ev = -EL_MAX;
        s.radius    = rad[CW-1:0];
        s.azimuth   = az[31 -: ANG_OUT_W];
        s.elevation = ev[ANG_OUT_W-1:0];
      end
      expected_q.push_back(s);
    endfunction

    function void check_result(sphere_t got);
      sphere_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: radius %0d azimuth %0d elevation %0d",
                   got.radius, got.azimuth, got.elevation);
        return;
      end
      want = expected_q.pop_front();
      if (got.radius !== want.radius || got.azimuth !== want.azimuth ||
          got.elevation !== want.elevation) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected radius %0d azimuth %0d elevation %0d, got %0d %0d %0d",
                   want.radius, want.azimuth, want.elevation,
                   got.radius, got.azimuth, got.elevation);
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  coord_t                      coord_x_i;
  coord_t                      coord_y_i;
  coord_t                      coord_z_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [CW-1:0]               radius_o;
  logic signed [ANG_OUT_W-1:0] azimuth_o;
  logic signed [ANG_OUT_W-1:0] elevation_o;

  sphere_scoreboard sphere_check;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               stall_count;

  cartesian_to_spherical dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .coord_z_i   (coord_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .radius_o    (radius_o),
    .azimuth_o   (azimuth_o),
    .elevation_o (elevation_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= px;
    coord_y_i  <= py;
    coord_z_i  <= pz;
    do @(posedge clk_i); while (!in_ready_o);
    sphere_check.note_request(px, py, pz);
  endtask

  task automatic send_random_point();
    coord_t r [3];
    coord_t corner [5];
    int     kind;
    corner = '{COORD_MIN, -1, 0, 1, COORD_MAX};
    kind   = $urandom_range(9);
    for (int k = 0; k < 3; k++) begin
      case (kind)
        5, 6: begin
          r[k] = coord_t'(int'($urandom_range(16)) - 8);
        end
        8: begin
          r[k] = corner[$urandom_range(4)];
        end
        default: begin
          r[k] = coord_t'($urandom);
        end
      endcase
    end
    if (kind == 7) begin
      r[0] = '0;
      r[1] = '0;
      if ($urandom_range(3) == 0) r[2] = '0;
    end
    if (kind == 9) begin
      r[0] = coord_t'(-int'($urandom_range(32768, 1)));
      r[1] = coord_t'(int'($urandom_range(6)) - 3);
    end
    send_point(r[0], r[1], r[2]);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sphere_check.check_result('{radius_o, azimuth_o, elevation_o});
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("cartesian_to_spherical_test failed");
      $finish;
    end
  end

  initial begin
    sphere_check  = new();
    send_idle_pct = 32;
    recv_idle_pct = 55;
    stall_count   = 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    coord_x_i     <= '0;
    coord_y_i     <= '0;
    coord_z_i     <= '0;
    out_ready_i   <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Origin, axes, the extremes and both sides of the negative x axis.
    send_point(0, 0, 0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MIN, 0, 0);
    send_point(-1, 0, 0);
    send_point(COORD_MAX, 0, 0);
    send_point(1, 0, 0);
    send_point(0, COORD_MAX, 0);
    send_point(0, COORD_MIN, 0);
    send_point(0, 0, COORD_MAX);
    send_point(0, 0, COORD_MIN);
    send_point(0, 0, 1);
    send_point(0, 0, -1);
    send_point(1, 1, 1);
    send_point(-1, -1, -1);
    send_point(COORD_MIN, -1, 0);
    send_point(COORD_MIN, 1, 0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN);
    send_point(COORD_MIN, COORD_MIN, COORD_MAX);
    send_point(1, 0, COORD_MIN);

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n == RANDOM_POINTS / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 32;
      end
      if (n == 2 * RANDOM_POINTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_point();
    end
    in_valid_i <= 1'b0;

    while (sphere_check.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sphere_check.mismatches == 0 && sphere_check.expected_q.size() == 0) begin
      $display("cartesian_to_spherical_test passed");
    end else begin
      $display("cartesian_to_spherical_test failed");
    end
    $finish;
  end

endmodule

>>> cartesian_to_spherical.f
sv/c2s_pkg.sv
sv/c2s_cell.sv
sv/c2s_scale.sv
sv/c2s_fmt.sv
sv/cartesian_to_spherical.sv
sim/cartesian_to_spherical_test.sv
